// ----- hw/rtl/tgql_pkg.sv -----
// tgql_pkg: types, register indexes and constants shared by the glyph quad layout block
// no dependencies

package tgql_pkg;

   // vertex counter width, saturates at all ones
   localparam int COUNT_BITS = 16;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ASCENDER         = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LINE_ADVANCE     = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LETTER_SPACING   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_LINE_WIDTH   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INV_ATLAS_WIDTH  = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INV_ATLAS_HEIGHT = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TEXT_COLOR       = 3'd6;

   localparam logic [7:0] CHAR_NEWLINE = 8'd10;
   localparam logic [7:0] CHAR_SPACE   = 8'd32;

   localparam logic KIND_VERTEX = 1'b0;
   localparam logic KIND_BOX    = 1'b1;

   typedef struct packed {
      logic               first;
      logic               last;
      logic [7:0]         char_code;
      logic [11:0]        advance;
      logic signed [11:0] bearing_x;
      logic signed [11:0] bearing_y;
      logic [11:0]        glyph_w;
      logic [11:0]        glyph_h;
      logic [11:0]        atlas_x;
      logic [11:0]        atlas_y;
      logic [11:0]        atlas_w;
      logic [11:0]        atlas_h;
   } req_type;

   typedef struct packed {
      logic               kind;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic [16:0]        tex_u;
      logic [16:0]        tex_v;
      logic [31:0]        color;
      logic [15:0]        vertex_index;
      logic [1:0]         corner;
      logic [15:0]        box_width;
      logic [15:0]        box_height;
      logic               last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [13:0] ascender;
      logic [14:0] line_advance;
      logic [11:0] letter_spacing;
      logic [14:0] max_line_width;
      logic [24:0] inv_atlas_width;
      logic [24:0] inv_atlas_height;
      logic [31:0] text_color;
   } cfg_type;

   // one laid-out item: quad corners, texture edges and the box that follows
   typedef struct packed {
      logic                  has_glyph;
      logic                  has_box;
      logic signed [15:0]    x0;
      logic signed [15:0]    y0;
      logic signed [15:0]    x1;
      logic signed [15:0]    y1;
      logic [16:0]           u0;
      logic [16:0]           u1;
      logic [16:0]           v0;
      logic [16:0]           v1;
      logic [COUNT_BITS-1:0] count;
      logic signed [15:0]    box_x;
      logic signed [15:0]    box_y;
      logic [15:0]           box_w;
      logic [15:0]           box_h;
   } quad_type;

endpackage

// ----- hw/rtl/tgql_csr.sv -----
// tgql_csr: configuration registers of the glyph quad layout block
// depends on tgql_pkg

module tgql_csr
   import tgql_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output cfg_type                   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_ASCENDER:         cfg_in.ascender         = csr_wdata[13:0];
            CSR_LINE_ADVANCE:     cfg_in.line_advance     = csr_wdata[14:0];
            CSR_LETTER_SPACING:   cfg_in.letter_spacing   = csr_wdata[11:0];
            CSR_MAX_LINE_WIDTH:   cfg_in.max_line_width   = csr_wdata[14:0];
            CSR_INV_ATLAS_WIDTH:  cfg_in.inv_atlas_width  = csr_wdata[24:0];
            CSR_INV_ATLAS_HEIGHT: cfg_in.inv_atlas_height = csr_wdata[24:0];
            CSR_TEXT_COLOR:       cfg_in.text_color       = csr_wdata;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ascender         <= 14'd0;
         cfg_ff.line_advance     <= 15'd256;
         cfg_ff.letter_spacing   <= 12'd256;
         cfg_ff.max_line_width   <= 15'd0;
         cfg_ff.inv_atlas_width  <= 25'd4096;
         cfg_ff.inv_atlas_height <= 25'd4096;
         cfg_ff.text_color       <= 32'hFFFF_FFFF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- hw/rtl/tgql_layout.sv -----
// tgql_layout: input register, pen and bounds state, and the per-character layout logic
// depends on tgql_pkg

module tgql_layout
   import tgql_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     req_valid,
   output logic     req_stall,
   input  req_type  req_data,
   output logic     q_valid,
   input  logic     q_ready,
   output quad_type q_data
);

   function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
      if (v > 20'sd32767) begin
         return 16'sh7FFF;
      end else if (v < -20'sd32768) begin
         return 16'sh8000;
      end else begin
         return v[15:0];
      end
   endfunction

   // (texel * inv + 128) >> 8, clamped to 1.0 in Q1.16
   function automatic logic [16:0] tex_coord(input logic [12:0] texel,
                                             input logic [24:0] inv);
      logic [37:0] prod;
      logic [29:0] p;
      prod = 38'(texel) * 38'(inv) + 38'd128;
      p    = prod[37:8];
      return (p > 30'd65536) ? 17'h10000 : p[16:0];
   endfunction

   logic    in_valid_ff, in_valid_in;
   req_type in_ff, in_in;

   logic signed [15:0]    pen_x_ff, pen_x_in, pen_y_ff, pen_y_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  have_ff, have_in;
   logic signed [15:0]    min_x_ff, min_x_in, min_y_ff, min_y_in;
   logic signed [15:0]    max_x_ff, max_x_in, max_y_ff, max_y_in;

   // state as seen by this character, after a string start
   logic signed [15:0]    cur_x, cur_y, cur_min_x, cur_min_y, cur_max_x, cur_max_y;
   logic [COUNT_BITS-1:0] cur_count;
   logic                  cur_have;

   logic                  is_newline, wrap, visible, has_results, in_take;
   logic signed [19:0]    wrap_sum, line_y;
   logic signed [15:0]    base_x, base_y, x0, y0, x1, y1;
   logic [23:0]           adv_prod;
   logic [24:0]           adv_round;
   logic [COUNT_BITS:0]   count_sum;

   always_comb begin
      if (in_ff.first) begin
         cur_x     = 16'sd0;
         cur_y     = signed'(16'(cfg.ascender));
         cur_count = '0;
         cur_have  = 1'b0;
         cur_min_x = 16'sd0;
         cur_min_y = 16'sd0;
         cur_max_x = 16'sd0;
         cur_max_y = 16'sd0;
      end else begin
         cur_x     = pen_x_ff;
         cur_y     = pen_y_ff;
         cur_count = count_ff;
         cur_have  = have_ff;
         cur_min_x = min_x_ff;
         cur_min_y = min_y_ff;
         cur_max_x = max_x_ff;
         cur_max_y = max_y_ff;
      end

      is_newline = (in_ff.char_code == CHAR_NEWLINE);
      line_y     = 20'(cur_y) + signed'(20'(cfg.line_advance));
      wrap_sum   = 20'(cur_x) + signed'(20'(in_ff.advance));
      wrap       = (cfg.max_line_width != 15'd0)
                   && (wrap_sum > signed'(20'(cfg.max_line_width)))
                   && (in_ff.char_code != CHAR_SPACE);

      if (is_newline || wrap) begin
         base_x = 16'sd0;
         base_y = sat16(line_y);
      end else begin
         base_x = cur_x;
         base_y = cur_y;
      end

      visible = !is_newline && (in_ff.glyph_w != 12'd0) && (in_ff.glyph_h != 12'd0);
      x0 = sat16(20'(base_x) + 20'(in_ff.bearing_x));
      y0 = sat16(20'(base_y) - 20'(in_ff.bearing_y));
      x1 = sat16(20'(x0) + signed'(20'(in_ff.glyph_w)));
      y1 = sat16(20'(y0) + signed'(20'(in_ff.glyph_h)));

      adv_prod  = 24'(in_ff.advance) * 24'(cfg.letter_spacing);
      adv_round = 25'(adv_prod) + 25'd128;

      pen_y_in = base_y;
      if (is_newline) begin
         pen_x_in = 16'sd0;
      end else begin
         pen_x_in = sat16(20'(base_x) + signed'(20'(adv_round[24:8])));
      end

      count_sum = {1'b0, cur_count} + (COUNT_BITS+1)'(4);
      have_in   = cur_have;
      count_in  = cur_count;
      min_x_in  = cur_min_x;
      min_y_in  = cur_min_y;
      max_x_in  = cur_max_x;
      max_y_in  = cur_max_y;
      if (visible) begin
         have_in  = 1'b1;
         count_in = (count_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX
                                                   : count_sum[COUNT_BITS-1:0];
         // x0 <= x1 and y0 <= y1, so only two corners can move the box
         if (!cur_have) begin
            min_x_in = x0;
            min_y_in = y0;
            max_x_in = x1;
            max_y_in = y1;
         end else begin
            min_x_in = (x0 < cur_min_x) ? x0 : cur_min_x;
            min_y_in = (y0 < cur_min_y) ? y0 : cur_min_y;
            max_x_in = (x1 > cur_max_x) ? x1 : cur_max_x;
            max_y_in = (y1 > cur_max_y) ? y1 : cur_max_y;
         end
      end

      q_data.has_glyph = visible;
      q_data.has_box   = in_ff.last;
      q_data.x0        = x0;
      q_data.y0        = y0;
      q_data.x1        = x1;
      q_data.y1        = y1;
      q_data.u0        = tex_coord(13'(in_ff.atlas_x), cfg.inv_atlas_width);
      q_data.u1        = tex_coord(13'(in_ff.atlas_x) + 13'(in_ff.atlas_w),
                                   cfg.inv_atlas_width);
      q_data.v0        = tex_coord(13'(in_ff.atlas_y), cfg.inv_atlas_height);
      q_data.v1        = tex_coord(13'(in_ff.atlas_y) + 13'(in_ff.atlas_h),
                                   cfg.inv_atlas_height);
      q_data.count     = cur_count;
      if (have_in) begin
         q_data.box_x = min_x_in;
         q_data.box_y = min_y_in;
         q_data.box_w = 16'(max_x_in - min_x_in);
         q_data.box_h = 16'(max_y_in - min_y_in);
      end else begin
         q_data.box_x = 16'sd0;
         q_data.box_y = 16'sd0;
         q_data.box_w = 16'd0;
         q_data.box_h = 16'd0;
      end
   end

   assign has_results = visible || in_ff.last;
   assign q_valid     = in_valid_ff && has_results;
   // a word with no results retires without waiting on the emitter
   assign in_take     = in_valid_ff && (!has_results || q_ready);
   assign req_stall   = in_valid_ff && !in_take;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_in       = in_ff;
      if (in_take) begin
         in_valid_in = 1'b0;
      end
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
         in_in       = req_data;
      end
   end

   always_ff @(posedge clock) begin
      in_ff <= in_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         pen_x_ff    <= 16'sd0;
         pen_y_ff    <= 16'sd0;
         count_ff    <= '0;
         have_ff     <= 1'b0;
         min_x_ff    <= 16'sd0;
         min_y_ff    <= 16'sd0;
         max_x_ff    <= 16'sd0;
         max_y_ff    <= 16'sd0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (in_take) begin
            pen_x_ff <= pen_x_in;
            pen_y_ff <= pen_y_in;
            count_ff <= count_in;
            have_ff  <= have_in;
            min_x_ff <= min_x_in;
            min_y_ff <= min_y_in;
            max_x_ff <= max_x_in;
            max_y_ff <= max_y_in;
         end
      end
   end

endmodule

// ----- hw/rtl/tgql_emit.sv -----
// tgql_emit: quad register and result register; sends corners and box one word a cycle unless rsp stalls
// depends on tgql_pkg

module tgql_emit
   import tgql_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     q_valid,
   output logic     q_ready,
   input  quad_type q_data,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   // steps 0..3 are the corners, the last step is the box
   localparam logic [2:0] STEP_BOX = 3'd4;

   logic     quad_valid_ff, quad_valid_in;
   quad_type quad_ff, quad_in;
   logic [2:0] step_ff, step_in;
   logic     out_valid_ff, out_valid_in;
   rsp_type  out_ff, out_in;

   logic out_load, last_step, right, bottom;
   logic [COUNT_BITS:0] idx_sum;
   logic [COUNT_BITS-1:0] idx;
   rsp_type cur;

   assign out_load  = !out_valid_ff || !rsp_stall;
   assign last_step = (step_ff == STEP_BOX) || ((step_ff == 3'd3) && !quad_ff.has_box);
   assign q_ready   = !quad_valid_ff || (last_step && out_load);

   always_comb begin
      right   = (step_ff == 3'd1) || (step_ff == 3'd2);
      bottom  = (step_ff == 3'd2) || (step_ff == 3'd3);
      idx_sum = {1'b0, quad_ff.count} + (COUNT_BITS+1)'(step_ff);
      idx     = (idx_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : idx_sum[COUNT_BITS-1:0];

      cur             = '0;
      cur.last_of_run = last_step;
      if (step_ff == STEP_BOX) begin
         cur.kind       = KIND_BOX;
         cur.pos_x      = quad_ff.box_x;
         cur.pos_y      = quad_ff.box_y;
         cur.box_width  = quad_ff.box_w;
         cur.box_height = quad_ff.box_h;
      end else begin
         cur.kind         = KIND_VERTEX;
         cur.pos_x        = right ? quad_ff.x1 : quad_ff.x0;
         cur.pos_y        = bottom ? quad_ff.y1 : quad_ff.y0;
         cur.tex_u        = right ? quad_ff.u1 : quad_ff.u0;
         cur.tex_v        = bottom ? quad_ff.v1 : quad_ff.v0;
         cur.color        = cfg.text_color;
         cur.vertex_index = 16'(idx);
         cur.corner       = step_ff[1:0];
      end
   end

   always_comb begin
      quad_valid_in = quad_valid_ff;
      quad_in       = quad_ff;
      step_in       = step_ff;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;

      if (out_load) begin
         out_valid_in = quad_valid_ff;
         if (quad_valid_ff) begin
            out_in  = cur;
            step_in = step_ff + 3'd1;
         end
      end

      if (q_ready) begin
         quad_valid_in = q_valid;
         if (q_valid) begin
            quad_in = q_data;
            step_in = q_data.has_glyph ? 3'd0 : STEP_BOX;
         end
      end
   end

   always_ff @(posedge clock) begin
      quad_ff <= quad_in;
      out_ff  <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quad_valid_ff <= 1'b0;
         step_ff       <= 3'd0;
         out_valid_ff  <= 1'b0;
      end else begin
         quad_valid_ff <= quad_valid_in;
         step_ff       <= step_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// ----- hw/rtl/text_glyph_quad_layout_core.sv -----
// text_glyph_quad_layout_core: top level of the glyph quad layout block
// depends on tgql_pkg, tgql_csr, tgql_layout, tgql_emit
//
// Usage:
//   req channel: one character word with its glyph metrics, taken when req_valid
//   is high and req_stall is low. first restarts pen, vertex count and bounds.
//   rsp channel: vertex words (four per visible glyph, corners in order
//   top-left, top-right, bottom-right, bottom-left) and, after a word marked
//   last, one bounding box word. last_of_run marks the final word of each input.
//   csr port: csr_write_en, csr_index, csr_wdata write one register per cycle;
//   write only while the block is idle.
// Timing:
//   a taken word goes from the input register to the quad register, then to
//   the result register, which sends one word per cycle while rsp is not
//   stalled: four per visible glyph, then a box word if last. A newline or blank
//   with no box retires without waiting on the emitter. A character is taken
//   every cycle while the quad register ahead of the result register has room.
// Reset: synchronous; clears all valids, pen, count and bounds, and loads the
//   register defaults. A stalled rsp holds its word; the quad register and the
//   input register then fill and req_stall rises.

module text_glyph_quad_layout_core
   import tgql_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_data,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   cfg_type  cfg;
   logic     q_valid, q_ready;
   quad_type q_data;

   tgql_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   tgql_layout u_layout (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_data    (q_data)
   );

   tgql_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_data    (q_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
